// ===== rtl/atrlm_pkg.sv =====
// Package for the AT response line matcher: item types, mode and status codes,
// and the byte patterns the matcher compares against.
// No dependencies.
`default_nettype none

package atrlm_pkg;

   // Mode codes of an input item.
   localparam logic [1:0] MODE_BYTE     = 2'd0;
   localparam logic [1:0] MODE_CMD_SENT = 2'd1;
   localparam logic [1:0] MODE_ABANDON  = 2'd2;

   // Status codes of a result item.
   localparam logic [1:0] STATUS_PENDING    = 2'd0;
   localparam logic [1:0] STATUS_OK         = 2'd1;
   localparam logic [1:0] STATUS_ERROR      = 2'd2;
   localparam logic [1:0] STATUS_NO_CARRIER = 2'd3;

   // Buffer geometry: twelve newest bytes, count saturates at the depth.
   localparam int unsigned TAIL_DEPTH = 12;
   localparam int unsigned TAIL_BITS  = TAIL_DEPTH * 8;
   localparam logic [3:0]  TAIL_FULL  = 4'd12;

   // Characters and patterns, first character in the most significant byte.
   localparam logic [7:0]  CHAR_LF      = 8'h0A;
   localparam logic [7:0]  CHAR_PROMPT  = 8'h3E;
   localparam logic [15:0] PAT_CRLF     = 16'h0D0A;
   localparam logic [15:0] PAT_ECHO     = 16'h4154;
   localparam logic [31:0] PAT_OK       = 32'h4F4B_0D0A;
   localparam logic [55:0] PAT_ERROR    = 56'h4552_524F_520D_0A;
   localparam logic [95:0] PAT_NO_CARR  = 96'h4E4F_2043_4152_5249_4552_0D0A;

   // Input item.
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [1:0] status;
      logic       receiving;
      logic       prompt_seen;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/atrlm_tracker.sv =====
// Line buffer and phase tracker of the AT response line matcher.
// Holds phase, sticky status and the buffer head and tail; gives the result
// of the item being applied. Depends on atrlm_pkg.
`default_nettype none

module atrlm_tracker
   import atrlm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   output rsp_type      rsp
);

   logic                 phase_ff, phase_in;
   logic [1:0]           code_ff, code_in;
   logic [TAIL_BITS-1:0] tail_ff, tail_in;
   logic [3:0]           held_ff, held_in;
   logic [15:0]          head_ff, head_in;

   // Buffer after taking the byte; newest byte sits in the low eight bits.
   logic [TAIL_BITS-1:0] push_tail;
   logic [3:0]           push_held;
   logic [15:0]          push_head;
   logic                 end_crlf, end_ok, end_error, end_no_carr;
   logic [1:0]           lf_code;

   always_comb begin
      push_tail = {tail_ff[TAIL_BITS-9:0], req.rx_byte};
      push_held = (held_ff < TAIL_FULL) ? held_ff + 4'd1 : TAIL_FULL;
      if (held_ff == 4'd0) begin
         push_head = {req.rx_byte, 8'h00};
      end else if (held_ff == 4'd1) begin
         push_head = {head_ff[15:8], req.rx_byte};
      end else begin
         push_head = head_ff;
      end
   end

   // Suffix compares, each needing enough buffered bytes.
   always_comb begin
      end_crlf    = (push_held >= 4'd2) && (push_tail[15:0] == PAT_CRLF);
      end_ok      = (push_held >= 4'd4) && (push_tail[31:0] == PAT_OK);
      end_error   = (push_held >= 4'd7) && (push_tail[55:0] == PAT_ERROR);
      end_no_carr = (push_held >= 4'd12) && (push_tail[95:0] == PAT_NO_CARR);
      priority if (end_ok) begin
         lf_code = STATUS_OK;
      end else if (end_error) begin
         lf_code = STATUS_ERROR;
      end else if (end_no_carr) begin
         lf_code = STATUS_NO_CARRIER;
      end else begin
         lf_code = code_ff;
      end
   end

   // Next state for one item.
   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      tail_in  = tail_ff;
      held_in  = held_ff;
      head_in  = head_ff;
      if (step) begin
         unique case (req.mode)
            MODE_BYTE: begin
               tail_in = push_tail;
               held_in = push_held;
               head_in = push_head;
               if (!phase_ff) begin
                  // Idle: drop each finished line, the echo starts receiving.
                  if (end_crlf) begin
                     if (push_head == PAT_ECHO) begin
                        phase_in = 1'b1;
                     end
                     tail_in = '0;
                     held_in = 4'd0;
                     head_in = 16'h0000;
                  end
               end else if (req.rx_byte == CHAR_LF) begin
                  code_in = lf_code;
                  if (lf_code != STATUS_PENDING) begin
                     phase_in = 1'b0;
                     tail_in  = '0;
                     held_in  = 4'd0;
                     head_in  = 16'h0000;
                  end
               end
            end
            MODE_CMD_SENT: begin
               phase_in = 1'b0;
               code_in  = STATUS_PENDING;
            end
            MODE_ABANDON: begin
               tail_in = '0;
               held_in = 4'd0;
               head_in = 16'h0000;
            end
            default: begin
               // Unused mode leaves the state as it is.
            end
         endcase
      end
   end

   // Result of the item, taken from the updated state.
   always_comb begin
      rsp.status      = code_in;
      rsp.receiving   = phase_in;
      rsp.prompt_seen = (held_in != 4'd0) && (tail_in[7:0] == CHAR_PROMPT);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         code_ff  <= STATUS_OK;
         tail_ff  <= '0;
         held_ff  <= 4'd0;
         head_ff  <= 16'h0000;
      end else begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         tail_ff  <= tail_in;
         held_ff  <= held_in;
         head_ff  <= head_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/at_response_line_matcher.sv =====
// An accepted item is held in the input register, then applied and registered in the result register on rsp_data.
// One item per cycle while rsp_stall is low; while a result waits, the input register takes an item only if empty.
// The rate is set by the tracker, which computes the new line buffer and status combinationally.
// Reset clears both valid flags, phase to idle, status to OK, and empties the buffer.
// Top level of the AT response line matcher; depends on atrlm_pkg and atrlm_tracker.
`default_nettype none

module at_response_line_matcher
   import atrlm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   rsp_type rsp_next;

   // An item moves on when the result register is empty or being taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   atrlm_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .step  (in_valid_ff && advance),
      .req   (in_data_ff),
      .rsp   (rsp_next)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/atrlm_checker.sv =====
// Port checker for the AT response line matcher, bound to the top level.
// Depends on atrlm_pkg.
`default_nettype none

module atrlm_checker
   import atrlm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Reset empties both stages.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // The input side only stalls behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // An accepted item reaches the output from the input register unless a stalled result blocks it.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("accepted item did not reach the output");

   // A stalled result item stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result item dropped or changed while stalled");

endmodule

bind at_response_line_matcher atrlm_checker u_atrlm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
